/* rtl/degree_limited_link_matrix_assert.svh */
// Assertion macros used by the link matrix RTL.
`ifndef DEGREE_LIMITED_LINK_MATRIX_ASSERT_SVH
`define DEGREE_LIMITED_LINK_MATRIX_ASSERT_SVH
`ifndef SYNTHESIS
`define DLL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DLL_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DLL_ASSERT(label, prop, msg)
`define DLL_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* rtl/dll_pkg.sv */
`default_nettype none
package dll_pkg;
	localparam int MAX_NODES = 64;
	localparam int NODE_W    = 6;
	localparam int ORD_W     = 7;
	localparam int CELL_AW   = 12;
	localparam int CELL_W    = 4;
	localparam int DEG_W     = 10;
	localparam int ADDED_W   = 12;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [CELL_W-1:0]  CELL_MAX  = 4'd15;
	localparam logic [DEG_W-1:0]   DEG_MAX   = 10'd1023;
	localparam logic [ADDED_W-1:0] ADDED_MAX = 12'd4095;

	typedef enum logic [2:0] {
		MODE_CLEAR    = 3'd0,
		MODE_PLACE    = 3'd1,
		MODE_COMPLETE = 3'd2,
		MODE_REMOVE   = 3'd3,
		MODE_READ     = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NODE_COUNT = 2'd0,
		CFG_MAX_MULT   = 2'd1,
		CFG_DUPLEX     = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_PRD, ST_PEV, ST_DRD, ST_DWR, ST_CRD, ST_CEV,
		ST_CFIN, ST_RRD, ST_REV, ST_FRD, ST_FLD, ST_DONE
	} state_t;
endpackage
`default_nettype wire

/* rtl/dll_ram.sv */
`default_nettype none
module dll_ram #(
	parameter int AW = 6,
	parameter int DW = 10
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/degree_limited_link_matrix.sv */
// Place probes one column per step, then writes the reverse link in duplex; complete
// visits every cell; out-of-range nodes or an unused mode go straight to the result.
// One item at a time; every cell visited goes through a read state and an evaluate/write state.
// Reset: config returns to order 16, cap 1, simplex; the block then sweeps the cell
// memory and both degree stores to zero with busy high.
// Each result shows for one cycle with done high; the receiver cannot stall.
`default_nettype none
`include "degree_limited_link_matrix_assert.svh"
module degree_limited_link_matrix (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [2:0]                       mode,
	input  wire logic [dll_pkg::NODE_W-1:0]       src_node,
	input  wire logic [dll_pkg::NODE_W-1:0]       dst_node,
	input  wire logic [dll_pkg::DEG_W-1:0]        degree_limit,
	input  wire logic                             cfg_we,
	input  wire logic [dll_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dll_pkg::CFG_W-1:0]        cfg_data,
	output logic                                  done,
	output logic                                  ok,
	output logic      [dll_pkg::NODE_W-1:0]       placed_column,
	output logic      [dll_pkg::CELL_W-1:0]       cell_value,
	output logic      [dll_pkg::DEG_W-1:0]        row_total,
	output logic      [dll_pkg::DEG_W-1:0]        col_total,
	output logic      [dll_pkg::ADDED_W-1:0]      links_added
);
	import dll_pkg::*;

	// Configuration registers
	logic [ORD_W-1:0]  node_count_q;
	logic [CELL_W-1:0] max_mult_q;
	logic              duplex_q;

	// Control and working registers
	state_t              state_q, state_d;
	logic [2:0]          mode_q;
	logic [NODE_W-1:0]   src_q, dst_q, col_q, row_q;
	logic [DEG_W-1:0]    lim_q;
	logic [NODE_W-1:0]   jump_q;
	logic [ORD_W-1:0]    probes_q;
	logic [ADDED_W-1:0]  added_q;
	logic                ok_q;
	logic                clr_out_q;
	logic [CELL_AW-1:0]  clr_idx_q;

	// Memory ports
	logic                cell_we, row_we, col_we;
	logic [CELL_AW-1:0]  cell_waddr, cell_raddr;
	logic [CELL_W-1:0]   cell_wdata, cell_rd;
	logic [NODE_W-1:0]   row_waddr, row_raddr, col_waddr, col_raddr;
	logic [DEG_W-1:0]    row_wdata, col_wdata, row_rd, col_rd;

	// Derived values
	logic [ORD_W-1:0]    order;
	logic                in_range;
	logic                may_add;
	logic [NODE_W-1:0]   cmp_row, cmp_col;
	logic [ORD_W-1:0]    col_sum;
	logic [NODE_W-1:0]   col_next;
	logic                probe_last;
	logic                scan_last;
	logic                rm_ok;
	logic [CELL_W-1:0]   cell_inc;
	logic [DEG_W-1:0]    row_inc, col_inc;

	// Saturate the order to 2..MAX_NODES
	always_comb begin
		if (node_count_q < ORD_W'(2)) begin
			order = ORD_W'(2);
		end else if (node_count_q > ORD_W'(MAX_NODES)) begin
			order = ORD_W'(MAX_NODES);
		end else begin
			order = node_count_q;
		end
	end

	assign in_range = ({1'b0, src_node} < order) && ({1'b0, dst_node} < order);

	// The row/column pair that the current read belongs to
	assign cmp_row = (state_q == ST_CEV) ? row_q : src_q;
	assign cmp_col = col_q;
	assign may_add = (cell_rd < max_mult_q) && (cmp_row != cmp_col) &&
	                 (row_rd < lim_q) && (col_rd < lim_q);

	// Next probe column: (col + jump) mod order, both below order
	assign col_sum    = {1'b0, col_q} + {1'b0, jump_q};
	assign col_next   = (col_sum >= order) ? NODE_W'(col_sum - order) : col_sum[NODE_W-1:0];
	assign probe_last = (probes_q + ORD_W'(1)) == order;
	assign scan_last  = ({1'b0, row_q} == order - ORD_W'(1)) &&
	                    ({1'b0, col_q} == order - ORD_W'(1));
	assign rm_ok      = (cell_rd != '0) && (row_rd > DEG_W'(1)) && (col_rd > DEG_W'(1));

	assign cell_inc = (cell_rd == CELL_MAX) ? cell_rd : cell_rd + CELL_W'(1);
	assign row_inc  = (row_rd == DEG_MAX) ? row_rd : row_rd + DEG_W'(1);
	assign col_inc  = (col_rd == DEG_MAX) ? col_rd : col_rd + DEG_W'(1);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_idx_q == '1) begin
					state_d = clr_out_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					unique case (mode)
						MODE_CLEAR:    state_d = ST_CLEAR;
						MODE_PLACE:    state_d = in_range ? ST_PRD : ST_DONE;
						MODE_COMPLETE: state_d = ST_CRD;
						MODE_REMOVE:   state_d = in_range ? ST_RRD : ST_DONE;
						MODE_READ:     state_d = in_range ? ST_FRD : ST_DONE;
						default:       state_d = ST_DONE;
					endcase
				end
			end
			ST_PRD: state_d = ST_PEV;
			ST_PEV: begin
				if (may_add) begin
					state_d = duplex_q ? ST_DRD : ST_FRD;
				end else if (probe_last) begin
					state_d = ST_FRD;
				end else begin
					state_d = ST_PRD;
				end
			end
			ST_DRD: state_d = ST_DWR;
			ST_DWR: state_d = ST_FRD;
			ST_CRD: state_d = ST_CEV;
			ST_CEV: state_d = scan_last ? ST_CFIN : ST_CRD;
			ST_CFIN: state_d = ST_DONE;
			ST_RRD: state_d = ST_REV;
			ST_REV: state_d = ST_FRD;
			ST_FRD: state_d = ST_FLD;
			ST_FLD: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory addressing and writes
	always_comb begin
		cell_raddr = {src_q, col_q};
		row_raddr  = src_q;
		col_raddr  = col_q;
		cell_we    = 1'b0;
		row_we     = 1'b0;
		col_we     = 1'b0;
		cell_waddr = {cmp_row, cmp_col};
		row_waddr  = cmp_row;
		col_waddr  = cmp_col;
		cell_wdata = cell_inc;
		row_wdata  = row_inc;
		col_wdata  = col_inc;
		unique case (state_q)
			ST_CLEAR: begin
				cell_we    = 1'b1;
				row_we     = 1'b1;
				col_we     = 1'b1;
				cell_waddr = clr_idx_q;
				row_waddr  = clr_idx_q[NODE_W-1:0];
				col_waddr  = clr_idx_q[NODE_W-1:0];
				cell_wdata = '0;
				row_wdata  = '0;
				col_wdata  = '0;
			end
			ST_PEV, ST_CEV: begin
				cell_we = may_add;
				row_we  = may_add;
				col_we  = may_add;
			end
			ST_DRD: begin
				// reverse link: row of the placed column, column of the source
				cell_raddr = {col_q, src_q};
				row_raddr  = col_q;
				col_raddr  = src_q;
			end
			ST_DWR: begin
				cell_we    = 1'b1;
				row_we     = 1'b1;
				col_we     = 1'b1;
				cell_waddr = {col_q, src_q};
				row_waddr  = col_q;
				col_waddr  = src_q;
			end
			ST_CRD: begin
				cell_raddr = {row_q, col_q};
				row_raddr  = row_q;
			end
			ST_REV: begin
				cell_we    = rm_ok;
				row_we     = rm_ok;
				col_we     = rm_ok;
				cell_wdata = cell_rd - CELL_W'(1);
				row_wdata  = row_rd - DEG_W'(1);
				col_wdata  = col_rd - DEG_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= ORD_W'(16);
			max_mult_q   <= CELL_W'(1);
			duplex_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NODE_COUNT: node_count_q <= cfg_data;
				CFG_MAX_MULT:   max_mult_q   <= cfg_data[CELL_W-1:0];
				CFG_DUPLEX:     duplex_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			clr_out_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + CELL_AW'(1);
			end
			if (state_q == ST_IDLE && start) begin
				clr_out_q <= 1'b1;
			end
		end
	end

	// Working registers and result fields
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					mode_q        <= mode;
					src_q         <= src_node;
					dst_q         <= dst_node;
					lim_q         <= degree_limit;
					col_q         <= (mode == MODE_COMPLETE) ? '0 : dst_node;
					row_q         <= '0;
					jump_q        <= order[ORD_W-1:1];
					probes_q      <= '0;
					added_q       <= '0;
					ok_q          <= (mode == MODE_READ);
					ok            <= 1'b0;
					placed_column <= '0;
					cell_value    <= '0;
					row_total     <= '0;
					col_total     <= '0;
					links_added   <= '0;
				end
			end
			ST_PEV: begin
				if (may_add) begin
					ok_q <= 1'b1;
				end else if (probe_last) begin
					col_q <= dst_q;
				end else begin
					col_q    <= col_next;
					jump_q   <= (jump_q > NODE_W'(1)) ? (jump_q >> 1) : NODE_W'(1);
					probes_q <= probes_q + ORD_W'(1);
				end
			end
			ST_CEV: begin
				if (may_add && added_q != ADDED_MAX) begin
					added_q <= added_q + ADDED_W'(1);
				end
				if ({1'b0, col_q} == order - ORD_W'(1)) begin
					col_q <= '0;
					row_q <= row_q + NODE_W'(1);
				end else begin
					col_q <= col_q + NODE_W'(1);
				end
			end
			ST_CFIN: begin
				ok          <= (added_q != '0);
				links_added <= added_q;
			end
			ST_REV: begin
				ok_q <= rm_ok;
			end
			ST_FLD: begin
				ok            <= ok_q;
				placed_column <= (ok_q && mode_q == MODE_PLACE) ? col_q : '0;
				cell_value    <= cell_rd;
				row_total     <= row_rd;
				col_total     <= col_rd;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	dll_ram #(.AW(CELL_AW), .DW(CELL_W)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.raddr (cell_raddr),
		.rdata (cell_rd)
	);

	dll_ram #(.AW(NODE_W), .DW(DEG_W)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.raddr (row_raddr),
		.rdata (row_rd)
	);

	dll_ram #(.AW(NODE_W), .DW(DEG_W)) u_col_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (col_waddr),
		.wdata (col_wdata),
		.raddr (col_raddr),
		.rdata (col_rd)
	);

	`DLL_ASSERT(a_busy_after_start, start && !busy |=> busy, "accepted item did not raise busy")
	`DLL_ASSERT(a_no_write_idle, !busy |-> !(cell_we || row_we || col_we), "memory write while idle")
	`DLL_ASSERT(a_idle_after_done, done |=> !busy, "block did not return to idle after a result")
	`DLL_ASSERT(a_place_not_self, done && ok && mode_q == MODE_PLACE |-> placed_column != src_q, "self link placed")
endmodule
`default_nettype wire
